>>> design/rrsp_pkg.sv
// Package for the round-robin server picker: sizes, operation and status codes,
// and the command and status structs that join the sequencer and the datapath.
// No dependencies.
package rrsp_pkg;

   // Table capacity and id space.
   localparam int MAX_SERVERS = 16;
   localparam int NUM_IDS     = 32;

   // Derived widths.
   localparam int ID_W     = $clog2(NUM_IDS);
   localparam int CNT_W    = $clog2(MAX_SERVERS + 1);
   localparam int IDX_W    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PICK   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd3;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic                capture;     // latch request, set up the walk pointer
      logic                add_write;   // append the id at the end of the table
      logic                scan_next;   // delete scan: step to the next entry
      logic                pick_next;   // pick walk: step with wrap, count a try
      logic                goto_last;   // remember the hit slot, read the last entry
      logic                move_last;   // last entry into hit slot, shrink, clamp index
      logic                set_index;   // rotating index follows the walk pointer
      logic                set_result;  // record the result of this request
      logic [STATUS_W-1:0] res_status;
      logic                res_valid;
      logic                out_load;    // move the recorded result to the output
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              count_zero;
      logic              count_full;
      logic              entry_match;
      logic              entry_writable;
      logic              last_entry;
      logic              last_try;
      logic              out_free;
   } stat_type;

endpackage

>>> design/rrsp_req_if.sv
// Request channel of the round-robin server picker: valid/ready handshake
// with the operation payload. Depends on rrsp_pkg.
interface rrsp_req_if;
   logic                          valid;
   logic                          ready;
   logic [rrsp_pkg::MODE_W-1:0]   mode;
   logic [rrsp_pkg::ID_W-1:0]     server_id;
   logic [rrsp_pkg::NUM_IDS-1:0]  writable_mask;

   modport source (output valid, output mode, output server_id, output writable_mask,
                   input ready);
   modport sink   (input valid, input mode, input server_id, input writable_mask,
                   output ready);
endinterface

// Response channel: valid/ready handshake with the result payload.
interface rrsp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rrsp_pkg::STATUS_W-1:0]   status;
   logic                            chosen_valid;
   logic [rrsp_pkg::ID_W-1:0]       chosen_id;
   logic [rrsp_pkg::CNT_W-1:0]      server_count;

   modport source (output valid, output status, output chosen_valid, output chosen_id,
                   output server_count, input ready);
   modport sink   (input valid, input status, input chosen_valid, input chosen_id,
                   input server_count, output ready);
endinterface

>>> design/rrsp_datapath.sv
// Datapath of the round-robin server picker: server table memory, count,
// rotating index, walk pointer and the response register. Depends on rrsp_pkg.
module rrsp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rrsp_pkg::cmd_type               cmd,
   output rrsp_pkg::stat_type              stat,
   input  logic [rrsp_pkg::MODE_W-1:0]     req_mode,
   input  logic [rrsp_pkg::ID_W-1:0]       req_server_id,
   input  logic [rrsp_pkg::NUM_IDS-1:0]    req_writable_mask,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [rrsp_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_chosen_valid,
   output logic [rrsp_pkg::ID_W-1:0]       rsp_chosen_id,
   output logic [rrsp_pkg::CNT_W-1:0]      rsp_server_count
);

   localparam int CNT_W = rrsp_pkg::CNT_W;
   localparam int IDX_W = rrsp_pkg::IDX_W;
   localparam int ID_W  = rrsp_pkg::ID_W;

   // Server table, one write and one registered read per cycle.
   logic [ID_W-1:0] table_mem [rrsp_pkg::MAX_SERVERS];
   logic [ID_W-1:0] entry_ff;

   // Latched request.
   logic [rrsp_pkg::MODE_W-1:0]  mode_ff;
   logic [ID_W-1:0]              id_ff;
   logic [rrsp_pkg::NUM_IDS-1:0] mask_ff;

   // Control state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] slot_ff;
   logic [CNT_W-1:0] tries_ff, tries_in;

   // Recorded result and output register.
   logic [rrsp_pkg::STATUS_W-1:0] pend_status_ff;
   logic                          pend_valid_ff;
   logic [ID_W-1:0]               pend_chosen_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrsp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_chosen_valid_ff;
   logic [ID_W-1:0]               rsp_chosen_id_ff;
   logic [CNT_W-1:0]              rsp_count_ff;

   logic [CNT_W-1:0] ptr_plus;
   logic [CNT_W-1:0] count_minus;

   assign ptr_plus    = CNT_W'(ptr_ff) + CNT_W'(1);
   assign count_minus = count_ff - CNT_W'(1);

   // Walk pointer: it is also the read address, so the registered entry
   // always shows the table slot that the pointer holds.
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.capture) begin
         if (req_mode == rrsp_pkg::MODE_PICK && index_ff < count_ff) begin
            ptr_in = index_ff[IDX_W-1:0];
         end else begin
            ptr_in = '0;
         end
      end else if (cmd.scan_next) begin
         ptr_in = ptr_plus[IDX_W-1:0];
      end else if (cmd.pick_next) begin
         ptr_in = (ptr_plus >= count_ff) ? '0 : ptr_plus[IDX_W-1:0];
      end else if (cmd.goto_last) begin
         ptr_in = count_minus[IDX_W-1:0];
      end
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.add_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.move_last) begin
         count_in = count_minus;
      end
   end

   // Rotating index: follows a pick, and is clamped after a delete.
   always_comb begin
      index_in = index_ff;
      if (cmd.set_index) begin
         index_in = ptr_plus;
      end else if (cmd.move_last) begin
         if (count_minus == '0) begin
            index_in = '0;
         end else if (index_ff >= count_minus) begin
            index_in = count_minus - CNT_W'(1);
         end
      end
   end

   // Try counter of the pick walk.
   always_comb begin
      tries_in = tries_ff;
      if (cmd.capture) begin
         tries_in = '0;
      end else if (cmd.pick_next) begin
         tries_in = tries_ff + CNT_W'(1);
      end
   end

   // Response valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         index_ff     <= '0;
         ptr_ff       <= '0;
         tries_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         index_ff     <= index_in;
         ptr_ff       <= ptr_in;
         tries_ff     <= tries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Table memory.
   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         table_mem[count_ff[IDX_W-1:0]] <= id_ff;
      end else if (cmd.move_last) begin
         table_mem[slot_ff] <= entry_ff;
      end
      entry_ff <= table_mem[ptr_in];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         id_ff   <= req_server_id;
         mask_ff <= req_writable_mask;
      end
      if (cmd.goto_last) begin
         slot_ff <= ptr_ff;
      end
      if (cmd.set_result) begin
         pend_status_ff <= cmd.res_status;
         pend_valid_ff  <= cmd.res_valid;
         pend_chosen_ff <= cmd.res_valid ? entry_ff : '0;
      end
      if (cmd.out_load) begin
         rsp_status_ff       <= pend_status_ff;
         rsp_chosen_valid_ff <= pend_valid_ff;
         rsp_chosen_id_ff    <= pend_chosen_ff;
         rsp_count_ff        <= count_ff;
      end
   end

   // Status to the sequencer.
   always_comb begin
      stat.mode           = mode_ff;
      stat.count_zero     = (count_ff == '0);
      stat.count_full     = (count_ff >= CNT_W'(rrsp_pkg::MAX_SERVERS));
      stat.entry_match    = (entry_ff == id_ff);
      stat.entry_writable = mask_ff[entry_ff];
      stat.last_entry     = (ptr_plus >= count_ff);
      stat.last_try       = (tries_ff + CNT_W'(1) >= count_ff);
      stat.out_free       = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_valid = rsp_chosen_valid_ff;
   assign rsp_chosen_id    = rsp_chosen_id_ff;
   assign rsp_server_count = rsp_count_ff;

endmodule

>>> design/rrsp_control.sv
// Sequencer of the round-robin server picker: steps each request through
// its table walk and issues commands to rrsp_datapath. Depends on rrsp_pkg.
module rrsp_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rrsp_pkg::stat_type stat,
   output rrsp_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_DEL_SCAN = 3'd2;
   localparam logic [2:0] ST_DEL_MOVE = 3'd3;
   localparam logic [2:0] ST_PICK     = 3'd4;
   localparam logic [2:0] ST_OUT      = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.set_result = 1'b1;
            cmd.res_status = rrsp_pkg::STATUS_OK;
            state_in       = ST_OUT;
            case (stat.mode)
               rrsp_pkg::MODE_ADD: begin
                  if (stat.count_full) begin
                     cmd.res_status = rrsp_pkg::STATUS_FULL;
                  end else begin
                     cmd.add_write = 1'b1;
                  end
               end
               rrsp_pkg::MODE_DELETE: begin
                  if (stat.count_zero) begin
                     cmd.res_status = rrsp_pkg::STATUS_MISSING;
                  end else begin
                     cmd.set_result = 1'b0;
                     state_in       = ST_DEL_SCAN;
                  end
               end
               rrsp_pkg::MODE_PICK: begin
                  if (stat.count_zero) begin
                     cmd.res_status = rrsp_pkg::STATUS_NONE;
                  end else begin
                     cmd.set_result = 1'b0;
                     state_in       = ST_PICK;
                  end
               end
               default: begin
                  // Unused operation: report an ok status with the current count only.
               end
            endcase
         end
         ST_DEL_SCAN: begin
            if (stat.entry_match) begin
               cmd.goto_last = 1'b1;
               state_in      = ST_DEL_MOVE;
            end else if (stat.last_entry) begin
               cmd.set_result = 1'b1;
               cmd.res_status = rrsp_pkg::STATUS_MISSING;
               state_in       = ST_OUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_DEL_MOVE: begin
            cmd.move_last  = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = rrsp_pkg::STATUS_OK;
            state_in       = ST_OUT;
         end
         ST_PICK: begin
            // Every try moves the rotating index past the tried slot.
            cmd.set_index = 1'b1;
            if (stat.entry_writable) begin
               cmd.set_result = 1'b1;
               cmd.res_status = rrsp_pkg::STATUS_OK;
               cmd.res_valid  = 1'b1;
               state_in       = ST_OUT;
            end else if (stat.last_try) begin
               cmd.set_result = 1'b1;
               cmd.res_status = rrsp_pkg::STATUS_NONE;
               state_in       = ST_OUT;
            end else begin
               cmd.pick_next = 1'b1;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/round_robin_server_picker_core.sv
// Round-robin server picker. Holds up to MAX_SERVERS server ids in a small
// table and serves add, delete and pick requests one at a time. A delete
// scans the table from slot zero until it finds the id, and a miss walks the
// whole table; a pick tries at most entry count slots from the rotating index.
// The single-ported table is walked one entry per cycle. The finished
// response sits in an output register; the next request is taken once that
// register has been loaded, even if the response is still waiting.
module round_robin_server_picker_core (
   input logic        clock,
   input logic        reset,
   rrsp_req_if.sink   req_chan,
   rrsp_rsp_if.source rsp_chan
);

   rrsp_pkg::cmd_type  cmd;
   rrsp_pkg::stat_type stat;

   // Request sequencer.
   rrsp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table, pointers and response register.
   rrsp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_chan.mode),
      .req_server_id     (req_chan.server_id),
      .req_writable_mask (req_chan.writable_mask),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_chosen_valid  (rsp_chan.chosen_valid),
      .rsp_chosen_id     (rsp_chan.chosen_id),
      .rsp_server_count  (rsp_chan.server_count)
   );

endmodule

>>> design/rrsp_checker.sv
// Port-level checks for round_robin_server_picker_core, bound to the top level.
// Depends on rrsp_pkg and the channel interfaces.
module rrsp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rrsp_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_chosen_valid,
   input logic [rrsp_pkg::ID_W-1:0]     rsp_chosen_id,
   input logic [rrsp_pkg::CNT_W-1:0]    rsp_server_count
);

   // A chosen server only comes with an ok status.
   a_chosen_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chosen_valid |-> rsp_status == rrsp_pkg::STATUS_OK)
      else $error("chosen server reported with a failing status");

   // Without a chosen server the id field reads zero.
   a_chosen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chosen_valid |-> rsp_chosen_id == '0)
      else $error("chosen id not zero without a chosen server");

   // A full report means the table holds its capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrsp_pkg::STATUS_FULL
      |-> rsp_server_count == rrsp_pkg::CNT_W'(rrsp_pkg::MAX_SERVERS))
      else $error("table full reported below capacity");

   // The count never exceeds the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_server_count <= rrsp_pkg::CNT_W'(rrsp_pkg::MAX_SERVERS))
      else $error("server count beyond capacity");

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

endmodule

bind round_robin_server_picker_core rrsp_checker u_rrsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_chosen_valid (rsp_chan.chosen_valid),
   .rsp_chosen_id    (rsp_chan.chosen_id),
   .rsp_server_count (rsp_chan.server_count)
);
